FILE: sv/fct_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the cluster link table.
// No dependencies; every other file refers to this package by scoped names.

package fct_pkg;

    localparam int LINK_W     = 11;   // one table entry, two's complement
    localparam int INDEX_W    = 10;   // index field on the ports
    localparam int OP_W       = 2;
    localparam int COUNT_W    = 11;   // free_count field
    localparam int BYTES_W    = 21;   // free_bytes field

    localparam int MAP_WORD_W = 32;   // free bits held in one bitmap word
    localparam int MAP_BIT_W  = 5;    // bit select inside a bitmap word
    localparam int MAP_SEL_W  = INDEX_W - MAP_BIT_W;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

    localparam logic [LINK_W-1:0] LINK_FREE = 11'h000;
    localparam logic [LINK_W-1:0] LINK_END  = 11'h7FF;

    // Entries 0..4 hold the boot chain after reset; everything above is free.
    localparam int LAYOUT_USED = 5;

    typedef struct packed {
        logic                 rd_en;      // read the bitmap word of rd_word
        logic [MAP_SEL_W-1:0] rd_word;
        logic                 upd_en;     // write one free bit (upd_free) into the word just read
        logic [INDEX_W-1:0]   upd_index;
        logic                 upd_free;
        logic                 scan;       // pick the lowest word holding a free bit
        logic                 fill_en;    // write the reset layout of one word
        logic [MAP_SEL_W-1:0] fill_word;
    } fm_cmd_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } fm_stat_t;

    // Link value of an entry in the reset layout.
    function automatic logic [LINK_W-1:0] layout_link(input logic [INDEX_W-1:0] entry);
        logic [LINK_W-1:0] link;
        if (entry == 10'd0 || entry == 10'd4)
        begin
            link = LINK_END;
        end
        else if (entry >= 10'd1 && entry <= 10'd3)
        begin
            link = {1'b0, entry} + 11'd1;
        end
        else
        begin
            link = LINK_FREE;
        end
        return link;
    endfunction

endpackage

FILE: sv/fct_link_ram.sv
`timescale 1ns / 1ps
// Link table storage: one write port, one read port, read data registered.
// Depends on fct_pkg for the entry width.

module fct_link_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [fct_pkg::LINK_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [fct_pkg::LINK_W-1:0] wr_data
);

    logic [fct_pkg::LINK_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/fct_free_map.sv
`timescale 1ns / 1ps
// Free bitmap: one bit per table entry in a word memory, plus a summary
// bit per word, searched in two steps for the lowest free entry. Uses fct_pkg.

module fct_free_map #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fct_pkg::fm_cmd_t  cmd,
    output fct_pkg::fm_stat_t stat
);

    localparam int WORD_W = fct_pkg::MAP_WORD_W;
    localparam int WORDS  = (TABLE_DEPTH + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [WORD_W-1:0] map_mem [WORDS];
    logic [WORD_W-1:0] map_q;
    logic [WORDS-1:0]  summary_reg;
    logic [WA_W-1:0]   sel_reg;
    logic              found_reg;

    logic [WA_W-1:0]   upd_addr;
    logic [WORD_W-1:0] upd_bits;
    logic [WA_W-1:0]   fill_addr;
    logic [WORD_W-1:0] fill_bits;
    logic [WA_W-1:0]   scan_sel;
    logic [WA_W-1:0]   rd_addr;
    logic [fct_pkg::MAP_BIT_W-1:0] low_bit;
    logic              wr_en;
    logic [WA_W-1:0]   wr_addr;
    logic [WORD_W-1:0] wr_bits;

    // Modify the word fetched with the item.
    always_comb
    begin
        upd_addr = cmd.upd_index[fct_pkg::MAP_BIT_W +: WA_W];
        upd_bits = map_q;
        upd_bits[cmd.upd_index[fct_pkg::MAP_BIT_W-1:0]] = cmd.upd_free;
    end

    // Reset layout of one word: free from the first spare entry up to the depth.
    always_comb
    begin
        int pos;
        fill_addr = cmd.fill_word[WA_W-1:0];
        for (int j = 0; j < WORD_W; j++)
        begin
            pos = int'(fill_addr) * WORD_W + j;
            fill_bits[j] = (pos >= fct_pkg::LAYOUT_USED) && (pos < TABLE_DEPTH);
        end
    end

    // Lowest word whose summary bit is set.
    always_comb
    begin
        scan_sel = '0;
        for (int w = WORDS - 1; w >= 0; w--)
        begin
            if (summary_reg[w])
            begin
                scan_sel = WA_W'(w);
            end
        end
    end

    // Lowest free bit of the selected word.
    always_comb
    begin
        low_bit = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (map_q[j])
            begin
                low_bit = fct_pkg::MAP_BIT_W'(j);
            end
        end
    end

    assign rd_addr = cmd.scan ? scan_sel : cmd.rd_word[WA_W-1:0];
    assign wr_en   = cmd.upd_en || cmd.fill_en;
    assign wr_addr = cmd.fill_en ? fill_addr : upd_addr;
    assign wr_bits = cmd.fill_en ? fill_bits : upd_bits;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_bits;
        end
        if (cmd.rd_en || cmd.scan)
        begin
            map_q <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary_reg <= '0;
            sel_reg     <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                summary_reg[wr_addr] <= |wr_bits;
            end
            if (cmd.scan)
            begin
                sel_reg   <= scan_sel;
                found_reg <= |summary_reg;
            end
        end
    end

    assign stat.found = found_reg;
    assign stat.index = fct_pkg::INDEX_W'({sel_reg, low_bit});

endmodule

FILE: sv/fat_cluster_table_unit.sv
`timescale 1ns / 1ps
// Top level of the cluster link table: sequencer, link RAM and free bitmap.
// Depends on fct_pkg, fct_link_ram and fct_free_map.
//
//  channel   ports                                       transfer
//  --------  ------------------------------------------  -------------------------
//  command   start, busy, operation, index, value        start high while busy low
//  result    done, read_value, write_rejected,           done high, one cycle,
//            first_free, free_count, free_bytes          no back-pressure
//
// After its transfer a read or write keeps busy high through the table and bitmap
// read-modify-write, then the summary scan; done is registered after the bitmap word
// search, which fills the result registers, and the next command can be taken during
// that search, before the last result is out.
// Reinitialize rewrites the whole table one entry per cycle in a clearing pass, then
// runs the read path. After reset the same clearing pass runs with busy high.
// Results cannot be held off by the receiver; done flags each for one cycle only.

module fat_cluster_table_unit #(
    parameter int ENTRIES       = 1024,
    parameter int CLUSTER_BYTES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [9:0]          index,
    input  logic signed [10:0]  value,
    output logic                done,
    output logic signed [10:0]  read_value,
    output logic                write_rejected,
    output logic signed [10:0]  first_free,
    output logic [10:0]         free_count,
    output logic [20:0]         free_bytes
);

    // Only the first 1024 entries are reachable through index; higher ones
    // stay free forever and only count.
    localparam int TABLE_DEPTH = (ENTRIES < 1024) ? ENTRIES : 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAP_WORDS   = (TABLE_DEPTH + fct_pkg::MAP_WORD_W - 1) / fct_pkg::MAP_WORD_W;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int CB_W        = $clog2(CLUSTER_BYTES + 1);
    localparam int PROD_W      = CNT_W + CB_W;
    localparam logic [fct_pkg::LINK_W-1:0] NONE_FREE =
        (ENTRIES > TABLE_DEPTH) ? fct_pkg::LINK_W'(TABLE_DEPTH) : fct_pkg::LINK_END;

    typedef enum logic [2:0] {
        ST_FILL,     // clearing pass, one entry per cycle
        ST_IDLE,
        ST_REREAD,   // read path after a reinitialize
        ST_UPDATE,   // table data back: modify and write
        ST_SCAN,     // summary search, fetch bitmap word
        ST_FIND      // bit search, load result registers
    } state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            fill_ctr_reg, fill_ctr_next;
    logic                        reinit_reg, reinit_next;
    logic [fct_pkg::OP_W-1:0]    op_reg, op_next;
    logic [fct_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [fct_pkg::LINK_W-1:0]  val_reg, val_next;
    logic                        in_table_reg, in_table_next;
    logic [fct_pkg::LINK_W-1:0]  link_reg, link_next;
    logic                        rej_reg, rej_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        done_reg, done_next;
    logic [fct_pkg::LINK_W-1:0]  out_link_reg, out_link_next;
    logic                        out_rej_reg, out_rej_next;
    logic [fct_pkg::LINK_W-1:0]  out_first_reg, out_first_next;
    logic [fct_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [fct_pkg::BYTES_W-1:0] out_bytes_reg, out_bytes_next;

    logic                        accept;
    logic                        in_table_now;
    logic                        fill_last;
    logic                        do_write;
    logic                        old_free;
    logic                        new_free;
    logic                        link_rd_en;
    logic [IDX_W-1:0]            link_rd_addr;
    logic [fct_pkg::LINK_W-1:0]  link_rd_data;
    logic                        link_wr_en;
    logic [IDX_W-1:0]            link_wr_addr;
    logic [fct_pkg::LINK_W-1:0]  link_wr_data;
    logic [PROD_W-1:0]           bytes_full;
    fct_pkg::fm_cmd_t            map_cmd;
    fct_pkg::fm_stat_t           map_stat;

    assign busy         = (state_reg != ST_IDLE) && (state_reg != ST_FIND);
    assign accept       = start && !busy;
    assign in_table_now = {1'b0, index} < fct_pkg::LINK_W'(TABLE_DEPTH);
    assign fill_last    = fill_ctr_reg == IDX_W'(TABLE_DEPTH - 1);

    // A write lands only with the sign bit clear and inside the table.
    assign do_write = (state_reg == ST_UPDATE) && (op_reg == fct_pkg::OP_WRITE)
                      && !val_reg[fct_pkg::LINK_W-1] && in_table_reg;
    assign old_free = link_rd_data == fct_pkg::LINK_FREE;
    assign new_free = val_reg == fct_pkg::LINK_FREE;

    // Fetch the entry and its bitmap word at the transfer, or again after a
    // reinitialize so that the result shows the fresh layout.
    assign link_rd_en   = (accept && operation != fct_pkg::OP_REINIT)
                          || (state_reg == ST_REREAD);
    assign link_rd_addr = (state_reg == ST_REREAD) ? idx_reg[IDX_W-1:0] : index[IDX_W-1:0];

    assign link_wr_en   = (state_reg == ST_FILL) || do_write;
    assign link_wr_addr = (state_reg == ST_FILL) ? fill_ctr_reg : idx_reg[IDX_W-1:0];
    assign link_wr_data = (state_reg == ST_FILL)
                          ? fct_pkg::layout_link(fct_pkg::INDEX_W'(fill_ctr_reg)) : val_reg;

    always_comb
    begin
        map_cmd.rd_en     = link_rd_en;
        map_cmd.rd_word   = (state_reg == ST_REREAD)
                            ? idx_reg[fct_pkg::INDEX_W-1:fct_pkg::MAP_BIT_W]
                            : index[fct_pkg::INDEX_W-1:fct_pkg::MAP_BIT_W];
        map_cmd.upd_en    = do_write;
        map_cmd.upd_index = idx_reg;
        map_cmd.upd_free  = new_free;
        map_cmd.scan      = state_reg == ST_SCAN;
        map_cmd.fill_en   = (state_reg == ST_FILL) && (int'(fill_ctr_reg) < MAP_WORDS);
        map_cmd.fill_word = fct_pkg::MAP_SEL_W'(fill_ctr_reg);
    end

    // Free space in bytes; count_reg settled in the update cycle.
    assign bytes_full = PROD_W'(count_reg) * PROD_W'(CLUSTER_BYTES);

    always_comb
    begin
        state_next     = state_reg;
        fill_ctr_next  = fill_ctr_reg;
        reinit_next    = reinit_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        in_table_next  = in_table_reg;
        link_next      = link_reg;
        rej_next       = rej_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        out_link_next  = out_link_reg;
        out_rej_next   = out_rej_reg;
        out_first_next = out_first_reg;
        out_count_next = out_count_reg;
        out_bytes_next = out_bytes_reg;

        unique case (state_reg)
            ST_FILL:
            begin
                if (fill_last)
                begin
                    count_next  = CNT_W'(ENTRIES - fct_pkg::LAYOUT_USED);
                    reinit_next = 1'b0;
                    state_next  = reinit_reg ? ST_REREAD : ST_IDLE;
                end
                else
                begin
                    fill_ctr_next = fill_ctr_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_REREAD:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Reinitialize arrives here as a plain read.
                if (!in_table_reg)
                begin
                    link_next = fct_pkg::LINK_END;
                end
                else if (do_write)
                begin
                    link_next = val_reg;
                end
                else
                begin
                    link_next = link_rd_data;
                end
                rej_next = (op_reg == fct_pkg::OP_WRITE) && val_reg[fct_pkg::LINK_W-1];
                if (do_write && old_free && !new_free)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else if (do_write && !old_free && new_free)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                done_next      = 1'b1;
                out_link_next  = link_reg;
                out_rej_next   = rej_reg;
                out_first_next = map_stat.found ? {1'b0, map_stat.index} : NONE_FREE;
                out_count_next = fct_pkg::COUNT_W'(count_reg);
                out_bytes_next = fct_pkg::BYTES_W'(bytes_full);
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Take a command; only possible while idle or finishing a result.
        if (accept)
        begin
            op_next       = operation;
            idx_next      = index;
            val_next      = value;
            in_table_next = in_table_now;
            if (operation == fct_pkg::OP_REINIT)
            begin
                fill_ctr_next = '0;
                reinit_next   = 1'b1;
                state_next    = ST_FILL;
            end
            else
            begin
                state_next = ST_UPDATE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_ctr_reg  <= '0;
            reinit_reg    <= 1'b0;
            op_reg        <= fct_pkg::OP_READ;
            idx_reg       <= '0;
            val_reg       <= '0;
            in_table_reg  <= 1'b0;
            link_reg      <= '0;
            rej_reg       <= 1'b0;
            count_reg     <= CNT_W'(ENTRIES - fct_pkg::LAYOUT_USED);
            done_reg      <= 1'b0;
            out_link_reg  <= '0;
            out_rej_reg   <= 1'b0;
            out_first_reg <= '0;
            out_count_reg <= '0;
            out_bytes_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_ctr_reg  <= fill_ctr_next;
            reinit_reg    <= reinit_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            in_table_reg  <= in_table_next;
            link_reg      <= link_next;
            rej_reg       <= rej_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            out_link_reg  <= out_link_next;
            out_rej_reg   <= out_rej_next;
            out_first_reg <= out_first_next;
            out_count_reg <= out_count_next;
            out_bytes_reg <= out_bytes_next;
        end
    end

    fct_link_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_link_ram (
        .clk     (clk),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    fct_free_map #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_free_map (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (map_cmd),
        .stat  (map_stat)
    );

    assign done           = done_reg;
    assign read_value     = $signed(out_link_reg);
    assign write_rejected = out_rej_reg;
    assign first_free     = $signed(out_first_reg);
    assign free_count     = out_count_reg;
    assign free_bytes     = out_bytes_reg;

endmodule
